### rtl/core/rnl_pkg.sv
// ----------------------------------------------------------------------------
// rnl_pkg: shared types and constants of the NACK list generator
// Table entry layout, result beat layout, register indexes and pass modes.
// ----------------------------------------------------------------------------
`default_nettype none

package rnl_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_RTT_MS      = 2'd0;
    localparam logic [1:0] REG_MAX_AGE     = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] RTT_MS_RESET      = 16'd100;
    localparam logic [15:0] MAX_AGE_RESET     = 16'd10000;
    localparam logic [7:0]  MAX_RETRIES_RESET = 8'd8;

    // Input commands
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Result kinds
    localparam logic KIND_NACK       = 1'b0;
    localparam logic KIND_FULL_FRAME = 1'b1;

    // What a copy pass over the table does
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,   // re-request entries past the round trip time
        MODE_DROP = 2'd1,   // remove the entry of a late packet
        MODE_JUMP = 2'd2    // age out, merge the new gap, request new entries
    } mode_t;

    // One missing sequence number
    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  retries;
        logic [39:0] sent_ms;
    } entry_t;

    // Request from the sequencer to the result stage
    typedef struct packed {
        logic        push;
        logic        flush;
        logic        kind;
        logic [15:0] nack_seq;
    } res_req_t;

endpackage

`default_nettype wire

### rtl/core/rnl_in_if.sv
// ----------------------------------------------------------------------------
// rnl_in_if: input channel of the NACK list generator
// Carries packet arrivals and retransmit timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface rnl_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] extended_seq;
    logic [39:0] now_ms;

    modport source (output valid, output command, output extended_seq, output now_ms,
                    input ready);
    modport sink   (input valid, input command, input extended_seq, input now_ms,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/rnl_out_if.sv
// ----------------------------------------------------------------------------
// rnl_out_if: result channel of the NACK list generator
// Carries NACK and full-frame requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface rnl_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] nack_seq;
    logic        last;

    modport source (output valid, output kind, output nack_seq, output last,
                    input ready);
    modport sink   (input valid, input kind, input nack_seq, input last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/rtp_nack_list_generator_top.sv
// ----------------------------------------------------------------------------
// rtp_nack_list_generator_top: receiver loss tracker for generic NACK
// Keeps an ascending table of missing sequence numbers and issues requests.
// ----------------------------------------------------------------------------
// One item is taken at a time. Each packet or tick is a copy pass over the
// table from one memory bank to the other, paced by the single read port.
// A forward jump first runs a counting pass over the entries for the age
// check. The first packet, a duplicate and the next packet in order need no
// pass. A pass stalls while the result channel is held back.
`default_nettype none

module rtp_nack_list_generator_top #(
    parameter int CAPACITY = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    rnl_in_if.sink      in_ch,
    rnl_out_if.source   out_ch
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CRD  = 7'b0000010,
        S_CCHK = 7'b0000100,
        S_DEC  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_EL   = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [15:0]          rtt_reg;
    logic [15:0]          max_age_reg;
    logic [7:0]           max_retries_reg;
    logic                 started_reg, started_next;
    logic [31:0]          newest_reg, newest_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 bank_reg, bank_next;
    logic [CW-1:0]        rp_reg, rp_next;
    logic [CW-1:0]        wp_reg, wp_next;
    logic [CW-1:0]        surv_reg, surv_next;
    rnl_pkg::mode_t       mode_reg, mode_next;
    logic [31:0]          seq_reg, seq_next;
    logic [39:0]          now_reg, now_next;
    logic [31:0]          thr_reg, thr_next;
    logic [31:0]          gap_reg, gap_next;

    rnl_pkg::entry_t      rd_data;
    rnl_pkg::entry_t      cand;
    rnl_pkg::entry_t      wr_data;
    rnl_pkg::res_req_t    req;
    logic                 req_ready;
    logic                 rd_en;
    logic                 wr_en;
    logic                 old_av, gap_av, take_old, take_gap, old_drop;
    logic                 due, retire, keep, emit, step_ok;
    logic [8:0]           new_retries;
    logic [32:0]          span;
    logic                 accept;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtt_reg         <= rnl_pkg::RTT_MS_RESET;
            max_age_reg     <= rnl_pkg::MAX_AGE_RESET;
            max_retries_reg <= rnl_pkg::MAX_RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rnl_pkg::REG_RTT_MS:      rtt_reg         <= cfg_data;
                rnl_pkg::REG_MAX_AGE:     max_age_reg     <= cfg_data;
                rnl_pkg::REG_MAX_RETRIES: max_retries_reg <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // Merge head: next stored entry against next gap number
    always_comb
    begin
        old_av   = (rp_reg < count_reg);
        gap_av   = (mode_reg == rnl_pkg::MODE_JUMP) && (gap_reg != seq_reg);
        take_old = old_av && (!gap_av || (rd_data.seq <= gap_reg));
        take_gap = gap_av && (!old_av || (gap_reg <= rd_data.seq));
        if (take_gap)
        begin
            cand.seq     = gap_reg;
            cand.retries = 8'd0;
            cand.sent_ms = 40'd0;
        end
        else
        begin
            cand = rd_data;
        end
        old_drop = take_old && !take_gap &&
                   (((mode_reg == rnl_pkg::MODE_DROP) && (rd_data.seq == seq_reg)) ||
                    ((mode_reg == rnl_pkg::MODE_JUMP) && (rd_data.seq < thr_reg)));
        case (mode_reg)
            rnl_pkg::MODE_TICK:
                due = ({1'b0, cand.sent_ms} + {25'd0, rtt_reg}) < {1'b0, now_reg};
            rnl_pkg::MODE_JUMP:
                due = (cand.retries == 8'd0) && (newest_reg >= cand.seq);
            default:
                due = 1'b0;
        endcase
        new_retries = {1'b0, cand.retries} + 9'd1;
        retire      = due && (new_retries >= {1'b0, max_retries_reg});
        keep        = !old_drop && !retire;
        emit        = due && !retire && !old_drop;
        step_ok     = !emit || req_ready;
        wr_data     = cand;
        if (due)
        begin
            wr_data.retries = new_retries[7:0];
            wr_data.sent_ms = now_reg;
        end
    end

    assign span = {1'b0, seq_reg - newest_reg - 32'd1} + {{(33 - CW){1'b0}}, surv_reg};

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        newest_next  = newest_reg;
        count_next   = count_reg;
        bank_next    = bank_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        surv_next    = surv_reg;
        mode_next    = mode_reg;
        seq_next     = seq_reg;
        now_next     = now_reg;
        thr_next     = thr_reg;
        gap_next     = gap_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        req          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    seq_next = in_ch.extended_seq;
                    now_next = in_ch.now_ms;
                    rp_next  = '0;
                    wp_next  = '0;
                    surv_next = '0;
                    thr_next = (in_ch.extended_seq >= {16'd0, max_age_reg}) ?
                               in_ch.extended_seq - {16'd0, max_age_reg} : 32'd0;
                    if (in_ch.command == rnl_pkg::CMD_TICK)
                    begin
                        mode_next  = rnl_pkg::MODE_TICK;
                        state_next = S_RD;
                    end
                    else if (!started_reg)
                    begin
                        started_next = 1'b1;
                        newest_next  = in_ch.extended_seq;
                    end
                    else if (in_ch.extended_seq == newest_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (in_ch.extended_seq == newest_reg + 32'd1)
                    begin
                        newest_next = in_ch.extended_seq;
                    end
                    else if (in_ch.extended_seq < newest_reg)
                    begin
                        mode_next  = rnl_pkg::MODE_DROP;
                        state_next = S_RD;
                    end
                    else
                    begin
                        mode_next  = rnl_pkg::MODE_JUMP;
                        state_next = S_CRD;
                    end
                end
            end
            S_CRD:
            begin
                if (rp_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_CCHK;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_CCHK:
            begin
                if (rd_data.seq >= thr_reg)
                begin
                    surv_next = surv_reg + CW'(1);
                end
                rp_next    = rp_reg + CW'(1);
                state_next = S_CRD;
            end
            S_DEC:
            begin
                newest_next = seq_reg;
                rp_next     = '0;
                wp_next     = '0;
                gap_next    = newest_reg + 32'd1;
                if (span > 33'(CAPACITY))
                begin
                    // Table would overflow: drop it all, ask for a full frame
                    req.push     = 1'b1;
                    req.kind     = rnl_pkg::KIND_FULL_FRAME;
                    req.nack_seq = 16'd0;
                    if (req_ready)
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                rd_en      = (rp_reg < count_reg);
                state_next = S_EL;
            end
            S_EL:
            begin
                if (!old_av && !gap_av)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    req.push     = emit;
                    req.kind     = rnl_pkg::KIND_NACK;
                    req.nack_seq = cand.seq[15:0];
                    if (step_ok)
                    begin
                        wr_en = keep;
                        if (keep)
                        begin
                            wp_next = wp_reg + CW'(1);
                        end
                        if (take_gap)
                        begin
                            gap_next = gap_reg + 32'd1;
                        end
                        if (take_old)
                        begin
                            rp_next    = rp_reg + CW'(1);
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_FIN:
            begin
                req.flush = 1'b1;
                if (req_ready)
                begin
                    bank_next  = !bank_reg;
                    count_next = wp_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            newest_reg  <= 32'd0;
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            rp_reg      <= '0;
            wp_reg      <= '0;
            surv_reg    <= '0;
            mode_reg    <= rnl_pkg::MODE_TICK;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            newest_reg  <= newest_next;
            count_reg   <= count_next;
            bank_reg    <= bank_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            surv_reg    <= surv_next;
            mode_reg    <= mode_next;
        end
    end

    // Item payload: no reset
    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        now_reg <= now_next;
        thr_reg <= thr_next;
        gap_reg <= gap_next;
    end

    rnl_table_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_bank (bank_reg),
        .rd_addr (rp_reg[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_bank (!bank_reg),
        .wr_addr (wp_reg[AW-1:0]),
        .wr_data (wr_data)
    );

    rnl_result_stage u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

### rtl/core/rnl_table_mem.sv
// ----------------------------------------------------------------------------
// rnl_table_mem: ping-pong table store
// Two banks of missing-sequence entries; one registered read, one write.
// ----------------------------------------------------------------------------
`default_nettype none

module rnl_table_mem #(
    parameter int CAPACITY = 64
) (
    input  wire                 clk,
    input  wire                 rd_en,
    input  wire                 rd_bank,
    input  wire  [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
    output rnl_pkg::entry_t     rd_data,
    input  wire                 wr_en,
    input  wire                 wr_bank,
    input  wire  [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
    input  rnl_pkg::entry_t     wr_data
);

    rnl_pkg::entry_t bank0_mem [CAPACITY];
    rnl_pkg::entry_t bank1_mem [CAPACITY];
    rnl_pkg::entry_t rd_data_reg;

    // Write the bank being built
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_bank)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
    end

    // Read the current bank; hold the data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rd_bank ? bank1_mem[rd_addr] : bank0_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/rnl_result_stage.sv
// ----------------------------------------------------------------------------
// rnl_result_stage: result holding and output register
// Holds one result back so that the final beat of an item can carry last.
// ----------------------------------------------------------------------------
`default_nettype none

module rnl_result_stage (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rnl_pkg::res_req_t   req,
    output logic                req_ready,
    rnl_out_if.source           out_ch
);

    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic        pend_kind_reg;
    logic [15:0] pend_seq_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_kind_reg;
    logic [15:0] out_seq_reg;
    logic        out_last_reg;
    logic        out_free;
    logic        move;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign req_ready = !pend_valid_reg || out_free;
    assign move      = (req.push || req.flush) && req_ready && pend_valid_reg;

    // Advance the held result to the output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        if (req.push && req_ready)
        begin
            pend_valid_next = 1'b1;
        end
        else if (req.flush && req_ready)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_kind_reg <= pend_kind_reg;
            out_seq_reg  <= pend_seq_reg;
            out_last_reg <= req.flush;
        end
        if (req.push && req_ready)
        begin
            pend_kind_reg <= req.kind;
            pend_seq_reg  <= req.nack_seq;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.kind     = out_kind_reg;
    assign out_ch.nack_seq = out_seq_reg;
    assign out_ch.last     = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/rnl_checker.sv
// ----------------------------------------------------------------------------
// rnl_checker: port-level checks of the NACK list generator
// Watches the input and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rnl_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_ready,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire         out_kind,
    input  wire  [15:0] out_nack_seq,
    input  wire         out_last
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_nack_seq) && $stable(out_last))
        else $error("result beat changed while stalled");

    // A full-frame request stands alone with a zero sequence
    a_full_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind |-> out_last && (out_nack_seq == 16'd0))
        else $error("full-frame beat malformed");

    // No new item is taken while an item still has results to come
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready in the middle of a result burst");

endmodule

bind rtp_nack_list_generator_top rnl_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_nack_seq (out_ch.nack_seq),
    .out_last     (out_ch.last)
);

`default_nettype wire
